[hw/rtl/pbf_pkg.sv]
// Package for the premultiplied RGB565 block fill: widths, stage payload types
// and the divide-by-255 rounding function. No dependencies.
`timescale 1ns / 1ps

package pbf_pkg;

  localparam int unsigned CoordW         = 8;
  localparam int unsigned SideW          = 4;
  localparam int unsigned ChanW          = 8;
  localparam int unsigned ProdW          = 16;
  localparam int unsigned IndexW         = 14;
  localparam int unsigned WordW          = 16;
  localparam int unsigned DefFrameWidth  = 128;
  localparam int unsigned DefFrameHeight = 115;
  localparam int unsigned DefMaxSide     = 8;

  typedef struct packed {
    logic [ProdW-1:0]  prod_r;
    logic [ProdW-1:0]  prod_g;
    logic [ProdW-1:0]  prod_b;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic              empty;
  } pbf_scaled_t;

  typedef struct packed {
    logic [WordW-1:0]  color;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [IndexW-1:0] row_base;
    logic              empty;
  } pbf_block_t;

  // Exact round(p / 255) for p <= 255 * 255.
  function automatic logic [ChanW-1:0] round_div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] t;
    logic [ProdW:0] u;
    t = {1'b0, p} + 17'd128;
    u = t + (t >> 8);
    return u[15:8];
  endfunction

endpackage

[hw/rtl/pbf_scale.sv]
// First stage: channel times alpha products and clipping of the block bounds.
// Depends on pbf_pkg.
`timescale 1ns / 1ps

module pbf_scale import pbf_pkg::*; #(
  parameter int unsigned FRAME_WIDTH    = DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT   = DefFrameHeight,
  parameter int unsigned MAX_BLOCK_SIDE = DefMaxSide
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CoordW-1:0] block_x,
  input  logic [CoordW-1:0] block_y,
  input  logic [SideW-1:0]  block_width,
  input  logic [SideW-1:0]  block_height,
  input  logic [ChanW-1:0]  red,
  input  logic [ChanW-1:0]  green,
  input  logic [ChanW-1:0]  blue,
  input  logic [ChanW-1:0]  alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output pbf_scaled_t       out_data
);

  localparam logic [SideW-1:0]  MaxSide = SideW'(MAX_BLOCK_SIDE);
  localparam logic [CoordW:0]   FrameW  = (CoordW+1)'(FRAME_WIDTH);
  localparam logic [CoordW:0]   FrameH  = (CoordW+1)'(FRAME_HEIGHT);

  logic [SideW-1:0] w_sat;
  logic [SideW-1:0] h_sat;
  logic [CoordW:0]  x_sum;
  logic [CoordW:0]  y_sum;
  pbf_scaled_t      data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    w_sat = (block_width  > MaxSide) ? MaxSide : block_width;
    h_sat = (block_height > MaxSide) ? MaxSide : block_height;
    x_sum = {1'b0, block_x} + {5'b0, w_sat};
    y_sum = {1'b0, block_y} + {5'b0, h_sat};
    data_next.prod_r = {8'b0, red}   * {8'b0, alpha};
    data_next.prod_g = {8'b0, green} * {8'b0, alpha};
    data_next.prod_b = {8'b0, blue}  * {8'b0, alpha};
    data_next.x0     = block_x;
    data_next.y0     = block_y;
    data_next.x1     = (x_sum > FrameW) ? FrameW[CoordW-1:0] : x_sum[CoordW-1:0];
    data_next.y1     = (y_sum > FrameH) ? FrameH[CoordW-1:0] : y_sum[CoordW-1:0];
    data_next.empty  = (data_next.x1 <= block_x) || (data_next.y1 <= block_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[hw/rtl/pbf_setup.sv]
// Second stage: rounds the scaled channels, packs RGB565, and forms the
// framebuffer index of the first row. Depends on pbf_pkg.
`timescale 1ns / 1ps

module pbf_setup import pbf_pkg::*; #(
  parameter int unsigned FRAME_WIDTH = DefFrameWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pbf_scaled_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pbf_block_t  out_data
);

  logic [ChanW-1:0] r_s;
  logic [ChanW-1:0] g_s;
  logic [ChanW-1:0] b_s;
  logic [15:0]      row_prod;
  pbf_block_t       data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    r_s      = round_div255(in_data.prod_r);
    g_s      = round_div255(in_data.prod_g);
    b_s      = round_div255(in_data.prod_b);
    row_prod = {8'b0, in_data.y0} * 16'(FRAME_WIDTH);
    data_next.color    = {r_s[7:3], g_s[7:2], b_s[7:3]};
    data_next.x0       = in_data.x0;
    data_next.y0       = in_data.y0;
    data_next.x1       = in_data.x1;
    data_next.y1       = in_data.y1;
    data_next.row_base = row_prod[IndexW-1:0];
    data_next.empty    = in_data.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[hw/rtl/pbf_walk.sv]
// Pixel walker: steps through the clipped block in row order and drives the
// registered pixel output. Depends on pbf_pkg.
`timescale 1ns / 1ps

module pbf_walk import pbf_pkg::*; #(
  parameter int unsigned FRAME_WIDTH = DefFrameWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbf_block_t        in_data,
  output logic              pixel_valid,
  input  logic              pixel_stall,
  output logic [IndexW-1:0] pixel_index,
  output logic [WordW-1:0]  pixel_word,
  output logic              last_pixel
);

  logic              busy;
  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic [CoordW-1:0] start_x;
  logic [CoordW-1:0] end_x;
  logic [CoordW-1:0] end_y;
  logic [WordW-1:0]  color;
  logic [IndexW-1:0] row_base;

  logic out_free;
  logic emit;
  logic x_end;
  logic y_end;
  logic last_now;
  logic load;

  always_comb begin
    out_free = !pixel_valid || !pixel_stall;
    emit     = busy && out_free;
    x_end    = ({1'b0, cur_x} + 9'd1) == {1'b0, end_x};
    y_end    = ({1'b0, cur_y} + 9'd1) == {1'b0, end_y};
    last_now = x_end && y_end;
    in_ready = !busy || (emit && last_now);
    load     = in_ready && in_valid && !in_data.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && last_now) begin
        busy <= 1'b0;
      end
      if (emit) begin
        pixel_valid <= 1'b1;
        pixel_index <= row_base + {6'b0, cur_x};
        pixel_word  <= color;
        last_pixel  <= last_now;
        if (!last_now) begin
          if (x_end) begin
            cur_x    <= start_x;
            cur_y    <= cur_y + 8'd1;
            row_base <= row_base + IndexW'(FRAME_WIDTH);
          end else begin
            cur_x <= cur_x + 8'd1;
          end
        end
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      if (load) begin
        cur_x    <= in_data.x0;
        cur_y    <= in_data.y0;
        start_x  <= in_data.x0;
        end_x    <= in_data.x1;
        end_y    <= in_data.y1;
        color    <= in_data.color;
        row_base <= in_data.row_base;
      end
    end
  end

endmodule

[hw/rtl/premultiplied_rgb565_block_fill.sv]
// Top level of the premultiplied RGB565 block fill: scale, setup and walker
// stages. Depends on pbf_pkg, pbf_scale, pbf_setup, pbf_walk.
//
//   channel | handshake                  | payload
//   block   | block_valid / block_stall  | block_x, block_y, block_width, block_height,
//           |                            | red, green, blue, alpha
//   pixel   | pixel_valid / pixel_stall  | pixel_index, pixel_word, last_pixel
//
// A block passes two register stages (products, then rounding and packing) and
// is loaded into the walker, which shows its first pixel on the registered output.
// The walker puts out one pixel per cycle unless pixel_stall holds it; a block
// covers 1 to 64 pixels by default; a fully clipped block takes one stage slot only.
// Reset (rst, synchronous) empties every stage. A stalled output holds the walker;
// block_stall rises once both stages before it are full and the walker takes none.
`timescale 1ns / 1ps

module premultiplied_rgb565_block_fill import pbf_pkg::*; #(
  parameter int unsigned FRAME_WIDTH    = DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT   = DefFrameHeight,
  parameter int unsigned MAX_BLOCK_SIDE = DefMaxSide
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              block_valid,
  output logic              block_stall,
  input  logic [CoordW-1:0] block_x,
  input  logic [CoordW-1:0] block_y,
  input  logic [SideW-1:0]  block_width,
  input  logic [SideW-1:0]  block_height,
  input  logic [ChanW-1:0]  red,
  input  logic [ChanW-1:0]  green,
  input  logic [ChanW-1:0]  blue,
  input  logic [ChanW-1:0]  alpha,
  output logic              pixel_valid,
  input  logic              pixel_stall,
  output logic [IndexW-1:0] pixel_index,
  output logic [WordW-1:0]  pixel_word,
  output logic              last_pixel
);

  logic        in_ready;
  logic        s1_valid;
  logic        s1_ready;
  pbf_scaled_t s1_data;
  logic        s2_valid;
  logic        s2_ready;
  pbf_block_t  s2_data;

  assign block_stall = !in_ready;

  pbf_scale #(
    .FRAME_WIDTH    (FRAME_WIDTH),
    .FRAME_HEIGHT   (FRAME_HEIGHT),
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (block_valid),
    .in_ready     (in_ready),
    .block_x      (block_x),
    .block_y      (block_y),
    .block_width  (block_width),
    .block_height (block_height),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .out_valid    (s1_valid),
    .out_ready    (s1_ready),
    .out_data     (s1_data)
  );

  pbf_setup #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  pbf_walk #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .in_data     (s2_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_index (pixel_index),
    .pixel_word  (pixel_word),
    .last_pixel  (last_pixel)
  );

endmodule

[hw/rtl/pbf_checker.sv]
// Port-level checks for premultiplied_rgb565_block_fill, bound to the top level.
// Depends on pbf_pkg.
`timescale 1ns / 1ps

module pbf_checker import pbf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              block_valid,
  input logic              block_stall,
  input logic              pixel_valid,
  input logic              pixel_stall,
  input logic [IndexW-1:0] pixel_index,
  input logic [WordW-1:0]  pixel_word,
  input logic              last_pixel
);

  logic pixel_xfer;
  assign pixel_xfer = pixel_valid && !pixel_stall;

  a_reset_clears: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel output valid after reset");

  a_block_held: assert property (@(posedge clk) disable iff (rst)
    block_valid && block_stall |=> block_valid)
    else $error("stalled block dropped before transfer");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_index)
      && $stable(pixel_word) && $stable(last_pixel))
    else $error("stalled pixel changed");

  a_block_continues: assert property (@(posedge clk) disable iff (rst)
    pixel_xfer && !last_pixel |=> pixel_valid)
    else $error("gap inside a block");

  a_color_constant: assert property (@(posedge clk) disable iff (rst)
    pixel_xfer && !last_pixel |=> pixel_word == $past(pixel_word))
    else $error("color changed inside a block");

endmodule

bind premultiplied_rgb565_block_fill pbf_checker u_pbf_checker (.*);
